### sv/eafr_pkg.sv
// Shared types and constants for the escaped API frame receiver.
// Used by the receiver top level and by its port checker; depends on nothing.
package eafr_pkg;

  // Framing bytes of the serial protocol.
  localparam logic [7:0] START_BYTE  = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0] ESCAPE_XOR  = 8'h20;
  localparam logic [7:0] CHECK_BASE  = 8'hFF;

  // Configuration register indexes.
  localparam logic REG_ESCAPED_MODE = 1'b0;

  // Kind of a result word.
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_GOOD   = 3'd2,
    KIND_CKERR  = 3'd3,
    KIND_TOOBIG = 3'd4
  } kind_e;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_WAIT   = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_CHECK  = 5'b10000
  } phase_e;

endpackage

### sv/escaped_api_frame_receiver.sv
// Escaped API frame receiver: byte-wise frame parser with an output register.
// Depends on eafr_pkg for framing constants, the result kind and the phase type.
//
// Usage
// The input channel (in_valid_i, in_stall_o, rx_byte_i) takes one received
// serial byte per word. The output channel (out_valid_o, out_stall_i and the
// result fields) gives exactly one result word for every accepted byte, with
// kind_o telling whether it carries nothing, a data byte with its index, or a
// frame verdict (good, checksum error, length too large).
// A byte's result is registered and shows in the cycle after the byte is
// accepted. Throughput is one byte per cycle while the output is not stalled,
// set by the single result register that holds the parser's output.
// When the receiver stalls, the result word holds and the input stalls in the
// same cycle only if the result register is still full, so a new byte enters
// whenever the waiting result is being taken.
// Reset (rst_ni low, asynchronous) empties the result register, returns the
// parser to hunting for a start byte and clears escaped mode.
// The APB port holds one register, escaped_mode, at byte address 0; it must be
// written only while the block is idle, and the block itself does not enforce this.
module escaped_api_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  // Output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output eafr_pkg::kind_e       kind_o,
  output logic [7:0]            data_byte_o,
  output logic [9:0]            byte_index_o,
  output logic [10:0]           frame_length_o
);

  // Counter of data bytes taken; it never exceeds the largest legal length.
  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);

  // Configuration register. The register index is the word address.
  logic mode_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == eafr_pkg::REG_ESCAPED_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == eafr_pkg::REG_ESCAPED_MODE) ? {31'd0, mode_q} : 32'd0;

  // Handshake: the result register frees up when its word is taken.
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Parser state.
  eafr_pkg::phase_e ph_q, ph_d;
  logic             inside_q, inside_d;
  logic             esc_q, esc_d;
  logic [15:0]      len_q, len_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;

  // Result fields for the byte being accepted.
  eafr_pkg::kind_e  kind_d, kind_q;
  logic [7:0]       db_d, db_q;
  logic [9:0]       idx_d, idx_q;
  logic [10:0]      flen_d, flen_q;

  // Working values: the state after a possible restart, and the decoded byte.
  eafr_pkg::phase_e ph_c;
  logic [15:0]      len_c;
  logic [CntW-1:0]  cnt_c;
  logic [7:0]       sum_c;
  logic [7:0]       b;
  logic             run_fsm;
  logic [15:0]      len_new;
  logic [CntW-1:0]  cnt_inc;

  always_comb begin
    ph_c     = ph_q;
    len_c    = len_q;
    cnt_c    = cnt_q;
    sum_c    = sum_q;
    b        = rx_byte_i;
    run_fsm  = 1'b1;
    inside_d = inside_q;
    esc_d    = esc_q;
    kind_d   = eafr_pkg::KIND_NONE;
    db_d     = 8'd0;
    idx_d    = 10'd0;
    flen_d   = 11'd0;
    len_new  = {len_q[15:8], b};
    cnt_inc  = cnt_q;

    // Front end: frame hunting, restart on a raw start byte in escaped mode, escape decoding.
    if (!inside_q) begin
      if (rx_byte_i != eafr_pkg::START_BYTE) begin
        run_fsm = 1'b0;
      end else begin
        ph_c     = eafr_pkg::PH_WAIT;
        len_c    = 16'd0;
        cnt_c    = '0;
        sum_c    = 8'd0;
        inside_d = 1'b1;
        esc_d    = 1'b0;
      end
    end else if (mode_q && (rx_byte_i == eafr_pkg::START_BYTE)) begin
      ph_c  = eafr_pkg::PH_WAIT;
      len_c = 16'd0;
      cnt_c = '0;
      sum_c = 8'd0;
      esc_d = 1'b0;
    end else if (mode_q) begin
      if (esc_q) begin
        b     = rx_byte_i ^ eafr_pkg::ESCAPE_XOR;
        esc_d = 1'b0;
      end else if (rx_byte_i == eafr_pkg::ESCAPE_BYTE) begin
        esc_d   = 1'b1;
        run_fsm = 1'b0;
      end
    end

    ph_d    = ph_c;
    len_d   = len_c;
    cnt_d   = cnt_c;
    sum_d   = sum_c;
    len_new = {len_c[15:8], b};
    cnt_inc = cnt_c + 1'b1;

    if (run_fsm) begin
      case (ph_c)
        eafr_pkg::PH_WAIT: begin
          if (b == eafr_pkg::START_BYTE) begin
            ph_d  = eafr_pkg::PH_LEN_HI;
            len_d = 16'd0;
            cnt_d = '0;
            sum_d = 8'd0;
          end
        end
        eafr_pkg::PH_LEN_HI: begin
          len_d = {b, 8'd0};
          ph_d  = eafr_pkg::PH_LEN_LO;
        end
        eafr_pkg::PH_LEN_LO: begin
          cnt_d = '0;
          sum_d = 8'd0;
          if (len_new > 16'(MAX_FRAME_BYTES)) begin
            // Oversized length: report it and go back to hunting.
            ph_d     = eafr_pkg::PH_WAIT;
            len_d    = 16'd0;
            inside_d = 1'b0;
            esc_d    = 1'b0;
            kind_d   = eafr_pkg::KIND_TOOBIG;
          end else begin
            len_d = len_new;
            ph_d  = (len_new == 16'd0) ? eafr_pkg::PH_CHECK : eafr_pkg::PH_DATA;
          end
        end
        eafr_pkg::PH_DATA: begin
          kind_d = eafr_pkg::KIND_DATA;
          db_d   = b;
          idx_d  = 10'(cnt_c);
          sum_d  = sum_c + b;
          cnt_d  = cnt_inc;
          if (16'(cnt_inc) >= len_c) begin
            ph_d = eafr_pkg::PH_CHECK;
          end
        end
        eafr_pkg::PH_CHECK: begin
          ph_d  = eafr_pkg::PH_WAIT;
          len_d = 16'd0;
          cnt_d = '0;
          sum_d = 8'd0;
          if ((eafr_pkg::CHECK_BASE - sum_c) != b) begin
            inside_d = 1'b0;
            esc_d    = 1'b0;
            kind_d   = eafr_pkg::KIND_CKERR;
          end else if (len_c != 16'd0) begin
            inside_d = 1'b0;
            esc_d    = 1'b0;
            kind_d   = eafr_pkg::KIND_GOOD;
            flen_d   = 11'(len_c);
          end
          // A good empty frame gives a result word of kind none and stays inside the frame,
          // so a decoded start byte may open the next one.
        end
        default: begin
          ph_d  = eafr_pkg::PH_WAIT;
          len_d = 16'd0;
          cnt_d = '0;
          sum_d = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= eafr_pkg::PH_WAIT;
      inside_q <= 1'b0;
      esc_q    <= 1'b0;
      len_q    <= 16'd0;
      cnt_q    <= '0;
      sum_q    <= 8'd0;
    end else if (accept) begin
      ph_q     <= ph_d;
      inside_q <= inside_d;
      esc_q    <= esc_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_d;
      db_q   <= db_d;
      idx_q  <= idx_d;
      flen_q <= flen_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = db_q;
  assign byte_index_o   = idx_q;
  assign frame_length_o = flen_q;

endmodule

### sv/eafr_checker.sv
// Port-level checker for the escaped API frame receiver, with its bind.
// Depends on eafr_pkg for the result kind codes.
module eafr_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_i,
  input logic                  out_valid_i,
  input logic                  out_stall_i,
  input eafr_pkg::kind_e       kind_i,
  input logic [7:0]            data_byte_i,
  input logic [9:0]            byte_index_i,
  input logic [10:0]           frame_length_i
);

  // Every accepted byte yields a result word in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) |=> out_valid_i)
    else $error("accepted byte produced no result word");

  // A stalled result word keeps its contents.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(kind_i)
      && $stable(data_byte_i) && $stable(byte_index_i) && $stable(frame_length_i)))
    else $error("stalled result word changed");

  // Data fields are zero unless the word carries a data byte.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (kind_i != eafr_pkg::KIND_DATA)) |->
      ((data_byte_i == 8'd0) && (byte_index_i == 10'd0)))
    else $error("data fields set on a non-data word");

  // The frame length is reported only with a good frame.
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (kind_i != eafr_pkg::KIND_GOOD)) |-> (frame_length_i == 11'd0))
    else $error("frame length set on a word that is not a good frame");

endmodule

bind escaped_api_frame_receiver eafr_checker u_eafr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_i     (in_stall_o),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_i         (kind_o),
  .data_byte_i    (data_byte_o),
  .byte_index_i   (byte_index_o),
  .frame_length_i (frame_length_o)
);
